// File: rtl/core/dbd_pkg.sv
package dbd_pkg;

    // fixed field widths
    localparam int MONTH_BITS = 4;
    localparam int DAY_BITS   = 5;
    localparam int DOY_BITS   = 9;
    localparam int COUNT_BITS = 21;
    localparam int REM_BITS   = 7;
    localparam int PC_BITS    = 3;

    localparam logic [REM_BITS:0]   CENTURY      = 8'd100;
    localparam logic [REM_BITS-1:0] LAST_IN_CENT = 7'd99;
    localparam logic [DOY_BITS-1:0] LEN_COMMON   = 9'd365;
    localparam logic [DOY_BITS-1:0] LEN_LEAP     = 9'd366;

    // reciprocal of 100 scaled by 2^23, exact quotient for years up to 16 bits
    localparam int                    RECIP_BITS  = 17;
    localparam int                    RECIP_SHIFT = 23;
    localparam logic [RECIP_BITS-1:0] RECIP_100   = 17'd83887;

    typedef logic [PC_BITS-1:0] pc_t;

    // datapath operations selected by the control word
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_DIV,
        OP_DOY1,
        OP_LOOP,
        OP_SAME,
        OP_OUT
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_TXN,
        COND_DIV_LAST,
        COND_SAME_YEAR,
        COND_YEAR_END,
        COND_OUT_TXN
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   tgt_true;
        pc_t   tgt_false;
    } ctrl_word_t;

    // controls into the century counter
    typedef struct packed {
        logic load;
        logic step;
        logic incr;
    } div_ctrl_t;

    // century counter status: year mod 100 and (year / 100) mod 4
    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic [1:0]          quo;
        logic                last;
    } div_stat_t;

    localparam pc_t PC_WAIT = 3'd0;
    localparam pc_t PC_DIV  = 3'd1;
    localparam pc_t PC_DOY1 = 3'd2;
    localparam pc_t PC_LOOP = 3'd3;
    localparam pc_t PC_SAME = 3'd4;
    localparam pc_t PC_OUT  = 3'd5;

    // microprogram rom
    function automatic ctrl_word_t microcode(input pc_t pc);
        ctrl_word_t cw;
        case (pc)
            PC_WAIT: cw = '{OP_WAIT, COND_IN_TXN,    PC_DIV,  PC_WAIT};
            PC_DIV:  cw = '{OP_DIV,  COND_DIV_LAST,  PC_DOY1, PC_DIV};
            PC_DOY1: cw = '{OP_DOY1, COND_SAME_YEAR, PC_SAME, PC_LOOP};
            PC_LOOP: cw = '{OP_LOOP, COND_YEAR_END,  PC_OUT,  PC_LOOP};
            PC_SAME: cw = '{OP_SAME, COND_ALWAYS,    PC_OUT,  PC_OUT};
            PC_OUT:  cw = '{OP_OUT,  COND_OUT_TXN,   PC_WAIT, PC_OUT};
            default: cw = '{OP_WAIT, COND_ALWAYS,    PC_WAIT, PC_WAIT};
        endcase
        return cw;
    endfunction

    // days in whole months before the month, common year, month saturated
    function automatic logic [DOY_BITS-1:0] month_base(input logic [MONTH_BITS-1:0] m);
        logic [DOY_BITS-1:0] b;
        case (m)
            4'd0, 4'd1: b = 9'd0;
            4'd2:       b = 9'd31;
            4'd3:       b = 9'd59;
            4'd4:       b = 9'd90;
            4'd5:       b = 9'd120;
            4'd6:       b = 9'd151;
            4'd7:       b = 9'd181;
            4'd8:       b = 9'd212;
            4'd9:       b = 9'd243;
            4'd10:      b = 9'd273;
            4'd11:      b = 9'd304;
            default:    b = 9'd334;
        endcase
        return b;
    endfunction

    function automatic logic [DOY_BITS-1:0] day_of_year(
        input logic [MONTH_BITS-1:0] m,
        input logic [DAY_BITS-1:0]   d,
        input logic                  leap
    );
        logic adj;
        adj = leap && (m >= 4'd3);
        return month_base(m) + {{(DOY_BITS-DAY_BITS){1'b0}}, d}
               + {{(DOY_BITS-1){1'b0}}, adj};
    endfunction

    function automatic logic [DOY_BITS-1:0] year_len(input logic leap);
        return leap ? LEN_LEAP : LEN_COMMON;
    endfunction

endpackage

// File: rtl/core/dbd_div100.sv
module dbd_div100 #(
    parameter int YEAR_BITS = 12
) (
    input  logic                  aclk,
    input  dbd_pkg::div_ctrl_t    ctrl,
    input  logic [YEAR_BITS-1:0]  year,
    output dbd_pkg::div_stat_t    stat
);

    localparam int PROD_BITS = YEAR_BITS + dbd_pkg::RECIP_BITS;

    logic [YEAR_BITS-1:0]         dv_reg, dv_next;
    logic [YEAR_BITS-1:0]         q_reg, q_next;
    logic                         qok_reg, qok_next;
    logic [dbd_pkg::REM_BITS-1:0] rem_reg, rem_next;
    logic [1:0]                   quo_reg, quo_next;
    logic [PROD_BITS-1:0]         prod;
    logic [YEAR_BITS-1:0]         hundreds;

    // quotient by reciprocal multiplication, then remainder from the quotient
    assign prod     = {{dbd_pkg::RECIP_BITS{1'b0}}, dv_reg}
                      * {{YEAR_BITS{1'b0}}, dbd_pkg::RECIP_100};
    assign hundreds = q_reg * YEAR_BITS'(dbd_pkg::CENTURY);

    // first step forms the quotient, second the remainder; then +1 with carry
    always_comb begin
        dv_next  = dv_reg;
        q_next   = q_reg;
        qok_next = qok_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (ctrl.load) begin
            dv_next  = year;
            qok_next = 1'b0;
        end else if (ctrl.step) begin
            if (!qok_reg) begin
                q_next   = YEAR_BITS'(prod >> dbd_pkg::RECIP_SHIFT);
                qok_next = 1'b1;
            end else begin
                rem_next = dbd_pkg::REM_BITS'(dv_reg - hundreds);
                quo_next = q_reg[1:0];
            end
        end else if (ctrl.incr) begin
            if (rem_reg == dbd_pkg::LAST_IN_CENT) begin
                rem_next = '0;
                quo_next = quo_reg + 2'd1;
            end else begin
                rem_next = rem_reg + dbd_pkg::REM_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        dv_reg  <= dv_next;
        q_reg   <= q_next;
        qok_reg <= qok_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.rem  = rem_reg;
    assign stat.quo  = quo_reg;
    assign stat.last = qok_reg;

endmodule

// File: rtl/core/days_between_dates.sv
// channel  | ports                                  | direction
// ---------+----------------------------------------+----------
// s_       | valid, ready, year/month/day a and b   | in
// m_       | valid, ready, day_count                | out
//
// the wait step takes the transaction, two divider steps find year mod 100 and the century,
// one step forms the first day of year, then one accumulate step per year of the gap (one
// difference step for equal years) and the output step, which holds until m_ready.
// synchronous active-low reset returns the step counter to the wait step.
// the result register holds until m_ready; no new input transaction is taken meanwhile.
module days_between_dates #(
    parameter int YEAR_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [YEAR_BITS-1:0]             s_year_a,
    input  logic [dbd_pkg::MONTH_BITS-1:0]   s_month_a,
    input  logic [dbd_pkg::DAY_BITS-1:0]     s_day_a,
    input  logic [YEAR_BITS-1:0]             s_year_b,
    input  logic [dbd_pkg::MONTH_BITS-1:0]   s_month_b,
    input  logic [dbd_pkg::DAY_BITS-1:0]     s_day_b,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dbd_pkg::COUNT_BITS-1:0]   m_day_count
);

    localparam int CB = dbd_pkg::COUNT_BITS;
    localparam int DB = dbd_pkg::DOY_BITS;

    dbd_pkg::pc_t        pc_reg, pc_next;
    dbd_pkg::ctrl_word_t cw;
    dbd_pkg::div_ctrl_t  div_ctrl;
    dbd_pkg::div_stat_t  div_stat;
    logic                cond_ok;

    logic [YEAR_BITS-1:0]           yc_reg, yc_next, y2_reg, y2_next;
    logic [dbd_pkg::MONTH_BITS-1:0] m1_reg, m1_next, m2_reg, m2_next;
    logic [dbd_pkg::DAY_BITS-1:0]   d1_reg, d1_next, d2_reg, d2_next;
    logic [DB-1:0]                  doy1_reg, doy1_next;
    logic [CB-1:0]                  acc_reg, acc_next;

    logic          swap, same_year, year_end, leap;
    logic [DB-1:0] doy1, doy2, ylen;

    assign cw        = dbd_pkg::microcode(pc_reg);
    assign swap      = s_year_a > s_year_b;
    assign same_year = yc_reg == y2_reg;
    assign year_end  = yc_reg == y2_reg;

    // gregorian leap test from the running residues of the current year
    assign leap = (yc_reg[1:0] == 2'b00) && ((div_stat.rem != '0) || (div_stat.quo == 2'b00));
    assign doy1 = dbd_pkg::day_of_year(m1_reg, d1_reg, leap);
    assign doy2 = dbd_pkg::day_of_year(m2_reg, d2_reg, leap);
    assign ylen = dbd_pkg::year_len(leap);

    // jump condition
    always_comb begin
        case (cw.cond)
            dbd_pkg::COND_ALWAYS:    cond_ok = 1'b1;
            dbd_pkg::COND_IN_TXN:    cond_ok = s_valid;
            dbd_pkg::COND_DIV_LAST:  cond_ok = div_stat.last;
            dbd_pkg::COND_SAME_YEAR: cond_ok = same_year;
            dbd_pkg::COND_YEAR_END:  cond_ok = year_end;
            dbd_pkg::COND_OUT_TXN:   cond_ok = m_ready;
            default:                 cond_ok = 1'b0;
        endcase
        pc_next = cond_ok ? cw.tgt_true : cw.tgt_false;
    end

    // datapath driven by the control word
    always_comb begin
        yc_next   = yc_reg;
        y2_next   = y2_reg;
        m1_next   = m1_reg;
        m2_next   = m2_reg;
        d1_next   = d1_reg;
        d2_next   = d2_reg;
        doy1_next = doy1_reg;
        acc_next  = acc_reg;
        div_ctrl  = '0;
        case (cw.op)
            dbd_pkg::OP_WAIT: begin
                if (s_valid) begin
                    // earlier year goes first
                    yc_next       = swap ? s_year_b  : s_year_a;
                    m1_next       = swap ? s_month_b : s_month_a;
                    d1_next       = swap ? s_day_b   : s_day_a;
                    y2_next       = swap ? s_year_a  : s_year_b;
                    m2_next       = swap ? s_month_a : s_month_b;
                    d2_next       = swap ? s_day_a   : s_day_b;
                    div_ctrl.load = 1'b1;
                end
            end
            dbd_pkg::OP_DIV: begin
                div_ctrl.step = 1'b1;
            end
            dbd_pkg::OP_DOY1: begin
                doy1_next = doy1;
                acc_next  = {{(CB-DB){1'b0}}, ylen - doy1};
                if (!same_year) begin
                    yc_next       = yc_reg + YEAR_BITS'(1);
                    div_ctrl.incr = 1'b1;
                end
            end
            dbd_pkg::OP_LOOP: begin
                if (year_end) begin
                    acc_next = acc_reg + {{(CB-DB){1'b0}}, doy2};
                end else begin
                    acc_next      = acc_reg + {{(CB-DB){1'b0}}, ylen};
                    yc_next       = yc_reg + YEAR_BITS'(1);
                    div_ctrl.incr = 1'b1;
                end
            end
            dbd_pkg::OP_SAME: begin
                acc_next = {{(CB-DB){1'b0}},
                            (doy1_reg > doy2) ? doy1_reg - doy2 : doy2 - doy1_reg};
            end
            dbd_pkg::OP_OUT: begin
                acc_next = acc_reg;
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= dbd_pkg::PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        yc_reg   <= yc_next;
        y2_reg   <= y2_next;
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        doy1_reg <= doy1_next;
        acc_reg  <= acc_next;
    end

    // year mod 100 and century mod 4
    dbd_div100 #(
        .YEAR_BITS(YEAR_BITS)
    ) u_div100 (
        .aclk (aclk),
        .ctrl (div_ctrl),
        .year (yc_next),
        .stat (div_stat)
    );

    assign s_ready     = cw.op == dbd_pkg::OP_WAIT;
    assign m_valid     = cw.op == dbd_pkg::OP_OUT;
    assign m_day_count = acc_reg;

endmodule

// File: test/tb_top.sv
module tb_top;

    localparam int YEAR_BITS     = 12;
    localparam int YEAR_MAX      = (1 << YEAR_BITS) - 1;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = YEAR_BITS + 8;
    localparam int QUIET_FROM    = 400;
    localparam int QUIET_TO      = 550;

    typedef struct packed {
        logic [YEAR_BITS-1:0]           year_a;
        logic [dbd_pkg::MONTH_BITS-1:0] month_a;
        logic [dbd_pkg::DAY_BITS-1:0]   day_a;
        logic [YEAR_BITS-1:0]           year_b;
        logic [dbd_pkg::MONTH_BITS-1:0] month_b;
        logic [dbd_pkg::DAY_BITS-1:0]   day_b;
    } date_pair_t;

    typedef struct packed {
        date_pair_t                     dates;
        logic [dbd_pkg::COUNT_BITS-1:0] count;
    } day_count_due_t;

    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [dbd_pkg::COUNT_BITS-1:0] m_day_count;
    date_pair_t                     offer   = '0;

    date_pair_t     date_pairs_q[$];
    day_count_due_t due_counts_q[$];
    int             sent_count  = 0;
    int             seen_count  = 0;
    int             error_count = 0;
    longint         cycle_count = 0;
    longint         cycle_limit = 64'h7fff_ffff_ffff_ffff;
    longint         work_cycles = 0;

    days_between_dates #(
        .YEAR_BITS(YEAR_BITS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_year_a   (offer.year_a),
        .s_month_a  (offer.month_a),
        .s_day_a    (offer.day_a),
        .s_year_b   (offer.year_b),
        .s_month_b  (offer.month_b),
        .s_day_b    (offer.day_b),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_day_count(m_day_count)
    );

    // gregorian leap rule, year 0 included
    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned year_days(input int unsigned y);
        return is_leap(y) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input bit leap_year);
        case (m)
            2:            return leap_year ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    // day of month plus all whole months before it; month saturates at december
    function automatic int unsigned ordinal_day(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        int unsigned total;
        int unsigned upto;
        total = d;
        upto  = (m > 12) ? 12 : m;
        for (int unsigned i = 1; i < upto; i++)
            total += days_in_month(i, is_leap(y));
        return total;
    endfunction

    // absolute distance in days between the two dates of a transaction
    function automatic logic [dbd_pkg::COUNT_BITS-1:0] days_apart(input date_pair_t p);
        int unsigned y1, m1, d1, y2, m2, d2;
        int unsigned doy_a, doy_b, total;
        if (p.year_a == p.year_b) begin
            doy_a = ordinal_day(p.year_a, p.month_a, p.day_a);
            doy_b = ordinal_day(p.year_b, p.month_b, p.day_b);
            total = (doy_a > doy_b) ? doy_a - doy_b : doy_b - doy_a;
        end else begin
            if (p.year_a > p.year_b) begin
                y1 = p.year_b; m1 = p.month_b; d1 = p.day_b;
                y2 = p.year_a; m2 = p.month_a; d2 = p.day_a;
            end else begin
                y1 = p.year_a; m1 = p.month_a; d1 = p.day_a;
                y2 = p.year_b; m2 = p.month_b; d2 = p.day_b;
            end
            total = year_days(y1) - ordinal_day(y1, m1, d1) + ordinal_day(y2, m2, d2);
            for (int unsigned y = y1 + 1; y < y2; y++)
                total += year_days(y);
        end
        return total[dbd_pkg::COUNT_BITS-1:0];
    endfunction

    // queue one date pair and account for its worst-case processing time
    task automatic add_dates(input int unsigned ya, input int unsigned ma, input int unsigned da,
                             input int unsigned yb, input int unsigned mb, input int unsigned db);
        date_pair_t p;
        p.year_a  = ya[YEAR_BITS-1:0];
        p.month_a = ma[dbd_pkg::MONTH_BITS-1:0];
        p.day_a   = da[dbd_pkg::DAY_BITS-1:0];
        p.year_b  = yb[YEAR_BITS-1:0];
        p.month_b = mb[dbd_pkg::MONTH_BITS-1:0];
        p.day_b   = db[dbd_pkg::DAY_BITS-1:0];
        date_pairs_q.push_back(p);
        work_cycles += YEAR_BITS + 8 + ((ya > yb) ? ya - yb : yb - ya);
    endtask

    // mostly legal months, now and then any 4-bit value
    function automatic int unsigned random_month();
        return ($urandom_range(0, 99) < 8) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    endfunction

    function automatic int unsigned random_day();
        return ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 31);
    endfunction

    // year gaps kept mostly short since the block loops once per year
    task automatic add_random_dates();
        int unsigned kind, gap, ya, yb, ma, mb, da, db, swap;
        kind = $urandom_range(0, 99);
        if (kind < 25)
            gap = 0;
        else if (kind < 80)
            gap = $urandom_range(1, 3);
        else if (kind < 97)
            gap = $urandom_range(4, 200);
        else
            gap = $urandom_range(201, YEAR_MAX);
        ya = $urandom_range(0, YEAR_MAX - gap);
        yb = ya + gap;
        ma = random_month();
        mb = (kind < 10) ? ma : random_month();
        da = random_day();
        db = random_day();
        if ($urandom_range(0, 1) == 1) begin
            swap = ya;
            ya   = yb;
            yb   = swap;
        end
        add_dates(ya, ma, da, yb, mb, db);
    endtask

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // stimulus, reset and end of run
    initial begin
        // directed cases
        add_dates(0, 1, 1, 0, 1, 1);
        add_dates(2023, 5, 1, 2023, 5, 31);
        add_dates(2023, 5, 31, 2023, 5, 1);
        add_dates(2024, 2, 28, 2024, 3, 1);
        add_dates(2023, 2, 28, 2023, 3, 1);
        add_dates(2023, 12, 31, 2023, 1, 1);
        add_dates(1900, 1, 1, 1901, 1, 1);
        add_dates(2000, 1, 1, 2001, 1, 1);
        add_dates(2100, 3, 1, 2099, 3, 1);
        add_dates(0, 1, 1, 1, 1, 1);
        add_dates(2001, 1, 1, 2000, 1, 1);
        add_dates(0, 1, 1, YEAR_MAX, 12, 31);
        add_dates(YEAR_MAX, 12, 31, 0, 0, 0);
        add_dates(YEAR_MAX, 15, 31, YEAR_MAX, 0, 0);
        add_dates(100, 0, 5, 100, 1, 5);
        add_dates(400, 13, 31, 401, 14, 31);
        add_dates(1999, 2, 31, 1999, 3, 1);
        add_dates(2, 4, 0, 3, 0, 31);
        add_dates(YEAR_MAX, 6, 15, YEAR_MAX - 1, 6, 15);
        add_dates(2047, 8, 16, 2048, 9, 17);
        add_dates(1, 10, 10, 0, 10, 10);
        add_dates(1600, 12, 31, 1600, 12, 31);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_random_dates();
        cycle_limit = 4 * work_cycles + 100 * date_pairs_q.size() + 20000;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // drain: nothing left to send, nothing in flight, nothing awaited
        @(negedge aclk);
        while (date_pairs_q.size() != 0 || s_valid || due_counts_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0 && due_counts_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        @(posedge aclk);
        while (cycle_count < cycle_limit)
            @(posedge aclk);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    // input driver: record accepted transaction, then offer the next one
    always @(posedge aclk) begin : feed
        day_count_due_t due;
        date_pair_t     nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                due.dates = offer;
                due.count = days_apart(offer);
                due_counts_q.push_back(due);
                sent_count++;
            end
            if (!s_valid || s_ready) begin
                if (date_pairs_q.size() != 0 &&
                    !((sent_count < QUIET_FROM || sent_count >= QUIET_TO) &&
                      $urandom_range(0, 99) < 19)) begin
                    nxt = date_pairs_q.pop_front();
                    offer   <= nxt;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge aclk) begin : watch
        day_count_due_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_counts_q.size() == 0) begin
                    $display("%0t: unexpected day_count transaction, expected none, actual %0d",
                             $time, m_day_count);
                    error_count++;
                end else begin
                    due = due_counts_q.pop_front();
                    if (m_day_count !== due.count) begin
                        $display({"%0t: day_count for %0d/%0d/%0d to %0d/%0d/%0d: ",
                                  "expected %0d, actual %0d"},
                                 $time, due.dates.year_a, due.dates.month_a, due.dates.day_a,
                                 due.dates.year_b, due.dates.month_b, due.dates.day_b,
                                 due.count, m_day_count);
                        error_count++;
                    end
                end
                seen_count++;
            end
            m_ready <= (seen_count >= QUIET_FROM && seen_count < QUIET_TO) ||
                       ($urandom_range(0, 99) >= 19);
        end
    end

endmodule
